@@ design/agm_pkg.sv @@
// shared types and constants for the adaptive gain audio mixer
// no dependencies; used by agm_mul, agm_div and adaptive_gain_audio_mixer
`timescale 1ns / 1ps
`default_nettype none

package agm_pkg;

  localparam int SAMPLE_W = 16;
  localparam int GAIN_W   = 17;
  localparam int SHIFT_W  = 4;

  localparam logic [GAIN_W-1:0]   GAIN_ONE          = 17'h10000;
  localparam logic [SAMPLE_W-1:0] LIMIT_POS         = 16'h7fff;
  localparam logic [SAMPLE_W-1:0] LIMIT_NEG_MAG     = 16'h8000;
  localparam logic [SHIFT_W-1:0]  RECOVERY_SHIFT_RST = 4'd5;

  // input transaction payload
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_a;
    logic signed [SAMPLE_W-1:0] sample_b;
    logic                       last_in_block;
  } agm_in_t;

  // result transaction payload
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] mixed_sample;
    logic                       clipped;
  } agm_out_t;

  // status of a serial arithmetic unit
  typedef struct packed {
    logic busy;
    logic done;
  } agm_unit_sts_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_FIN
  } agm_state_t;

endpackage

`default_nettype wire

@@ design/adaptive_gain_audio_mixer.sv @@
// top level of the adaptive gain audio mixer
// depends on agm_pkg, agm_mul and agm_div
`timescale 1ns / 1ps
`default_nettype none

// Mixes two signed 16-bit PCM samples per transaction: the sum is scaled by a
// running Q1.16 gain (truncated toward zero) and clipped to 16 bits; on a clip
// the gain becomes limit / scaled sum, then recovers toward unity by
// (1 - gain) >> recovery_shift each sample, and returns to unity after a
// sample flagged last_in_block. One transaction is in work at a time. Its
// pace is set by the 17-step bit-serial multiplier; a clipping transaction
// also runs the 16-step restoring divider after the multiplier. The result
// sits in an output register, so a new transaction is taken while the
// previous result still waits. recovery_shift (reset 5) is written through
// the cfg port, which is always ready; write it only while the block is idle.

module adaptive_gain_audio_mixer (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire agm_pkg::agm_in_t              in_data,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output agm_pkg::agm_out_t                  out_data,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [agm_pkg::SHIFT_W-1:0]   cfg_data
);

  localparam int SW = agm_pkg::SAMPLE_W;
  localparam int GW = agm_pkg::GAIN_W;

  agm_pkg::agm_state_t    state_r, state_nxt;
  logic [GW-1:0]          gain_r, gain_nxt;
  logic [agm_pkg::SHIFT_W-1:0] shift_r, shift_nxt;
  logic                   neg_r, neg_nxt;
  logic                   last_r, last_nxt;
  logic [SW-1:0]          res_r, res_nxt;
  logic                   clip_r, clip_nxt;
  logic                   out_valid_r, out_valid_nxt;
  agm_pkg::agm_out_t      out_data_r, out_data_nxt;

  logic                   in_accept;
  logic signed [SW:0]     sum;
  logic [GW-1:0]          in_mag;
  logic                   in_neg;
  logic                   mul_start;
  logic                   div_start;
  agm_pkg::agm_unit_sts_t mul_sts;
  agm_pkg::agm_unit_sts_t div_sts;
  logic [GW-1:0]          smag;
  logic [SW-1:0]          quot;
  logic [SW-1:0]          div_limit;
  logic                   clip_pos;
  logic                   clip_neg;
  logic [GW-1:0]          shortfall;
  logic [GW-1:0]          gain_rec;

  assign in_stall  = (state_r != agm_pkg::ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // sum of the pair and its magnitude
  assign sum    = {in_data.sample_a[SW-1], in_data.sample_a}
                + {in_data.sample_b[SW-1], in_data.sample_b};
  assign in_neg = sum[SW];
  assign in_mag = in_neg ? GW'(-sum) : GW'(sum);

  agm_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .mag   (in_mag),
    .gain  (gain_r),
    .sts   (mul_sts),
    .smag  (smag)
  );

  assign div_limit = neg_r ? agm_pkg::LIMIT_NEG_MAG : agm_pkg::LIMIT_POS;

  agm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .limit (div_limit),
    .denom (smag),
    .sts   (div_sts),
    .quot  (quot)
  );

  // limit checks on the scaled magnitude
  assign clip_pos = !neg_r && (smag > {1'b0, agm_pkg::LIMIT_POS});
  assign clip_neg = neg_r && (smag > {1'b0, agm_pkg::LIMIT_NEG_MAG});

  // recovery toward unity
  assign shortfall = agm_pkg::GAIN_ONE - gain_r;
  assign gain_rec  = gain_r + (shortfall >> shift_r);

  // sequencer: next state and datapath controls
  always_comb begin
    state_nxt     = state_r;
    gain_nxt      = gain_r;
    shift_nxt     = cfg_valid ? cfg_data : shift_r;
    neg_nxt       = neg_r;
    last_nxt      = last_r;
    res_nxt       = res_r;
    clip_nxt      = clip_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    mul_start     = 1'b0;
    div_start     = 1'b0;
    unique case (state_r)
      agm_pkg::ST_IDLE: begin
        if (in_accept) begin
          neg_nxt   = in_neg;
          last_nxt  = in_data.last_in_block;
          mul_start = 1'b1;
          state_nxt = agm_pkg::ST_MUL;
        end
      end
      agm_pkg::ST_MUL: begin
        if (mul_sts.done) begin
          if (clip_pos || clip_neg) begin
            clip_nxt  = 1'b1;
            res_nxt   = neg_r ? agm_pkg::LIMIT_NEG_MAG : agm_pkg::LIMIT_POS;
            div_start = 1'b1;
            state_nxt = agm_pkg::ST_DIV;
          end else begin
            clip_nxt  = 1'b0;
            res_nxt   = neg_r ? SW'(-smag) : smag[SW-1:0];
            state_nxt = agm_pkg::ST_FIN;
          end
        end
      end
      agm_pkg::ST_DIV: begin
        if (div_sts.done) begin
          gain_nxt  = {1'b0, quot};
          state_nxt = agm_pkg::ST_FIN;
        end
      end
      agm_pkg::ST_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt.mixed_sample = res_r;
          out_data_nxt.clipped      = clip_r;
          gain_nxt  = last_r ? agm_pkg::GAIN_ONE : gain_rec;
          state_nxt = agm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = agm_pkg::ST_IDLE;
      end
    endcase
  end

  // state and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= agm_pkg::ST_IDLE;
      gain_r      <= agm_pkg::GAIN_ONE;
      shift_r     <= agm_pkg::RECOVERY_SHIFT_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      gain_r      <= gain_nxt;
      shift_r     <= shift_nxt;
      out_valid_r <= out_valid_nxt;
    end
    neg_r      <= neg_nxt;
    last_r     <= last_nxt;
    res_r      <= res_nxt;
    clip_r     <= clip_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // gain never rises above unity
  a_gain_max: assert property (@(posedge clk) disable iff (!rst_n)
    gain_r <= agm_pkg::GAIN_ONE)
    else $error("gain above unity");

  // multiplier and divider never run together
  a_units_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(mul_sts.busy && div_sts.busy))
    else $error("multiplier and divider busy at once");

  // a new result only comes out of the finish state
  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == agm_pkg::ST_FIN))
    else $error("result loaded outside finish state");

  // a clipped result carries one of the limits
  a_clip_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.clipped) |->
      (out_data_r.mixed_sample == agm_pkg::LIMIT_POS ||
       out_data_r.mixed_sample == agm_pkg::LIMIT_NEG_MAG))
    else $error("clipped result not at a limit");

endmodule

`default_nettype wire

@@ design/agm_mul.sv @@
// bit-serial shift-add multiplier: 17-bit magnitude times 17-bit Q1.16 gain
// returns (mag * gain) >> 16; depends on agm_pkg
`timescale 1ns / 1ps
`default_nettype none

module agm_mul (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [agm_pkg::GAIN_W-1:0]  mag,
  input  wire logic [agm_pkg::GAIN_W-1:0]  gain,
  output agm_pkg::agm_unit_sts_t           sts,
  output logic [agm_pkg::GAIN_W-1:0]       smag
);

  localparam int W = agm_pkg::GAIN_W;
  localparam int CNT_W = $clog2(W);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(W - 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [W-1:0]     mcand_r, mcand_nxt;
  logic [W-1:0]     hi_r, hi_nxt;
  logic [W-1:0]     lo_r, lo_nxt;
  logic [W:0]       add_sum;

  // one partial product per cycle, lsb of the gain first
  always_comb begin
    add_sum   = {1'b0, hi_r} + (lo_r[0] ? {1'b0, mcand_r} : '0);
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    cnt_nxt   = cnt_r;
    mcand_nxt = mcand_r;
    hi_nxt    = hi_r;
    lo_nxt    = lo_r;
    if (start) begin
      busy_nxt  = 1'b1;
      cnt_nxt   = '0;
      mcand_nxt = mag;
      hi_nxt    = '0;
      lo_nxt    = gain;
    end else if (busy_r) begin
      hi_nxt  = add_sum[W:1];
      lo_nxt  = {add_sum[0], lo_r[W-1:1]};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == LAST_STEP) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r   <= cnt_nxt;
    mcand_r <= mcand_nxt;
    hi_r    <= hi_nxt;
    lo_r    <= lo_nxt;
  end

  // product bits 32..16
  assign smag     = {hi_r[W-2:0], lo_r[W-1]};
  assign sts.busy = busy_r;
  assign sts.done = done_r;

endmodule

`default_nettype wire

@@ design/agm_div.sv @@
// restoring divider, one quotient bit per cycle: floor(limit * 65536 / denom)
// requires limit < denom; depends on agm_pkg
`timescale 1ns / 1ps
`default_nettype none

module agm_div (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [agm_pkg::SAMPLE_W-1:0]  limit,
  input  wire logic [agm_pkg::GAIN_W-1:0]    denom,
  output agm_pkg::agm_unit_sts_t             sts,
  output logic [agm_pkg::SAMPLE_W-1:0]       quot
);

  localparam int QW = agm_pkg::SAMPLE_W;
  localparam int DW = agm_pkg::GAIN_W;
  localparam int CNT_W = $clog2(QW);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(QW - 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DW-1:0]    den_r, den_nxt;
  logic [DW-1:0]    rem_r, rem_nxt;
  logic [QW-1:0]    q_r, q_nxt;
  logic [DW:0]      rem2;
  logic [DW:0]      diff;
  logic             fits;

  // shift remainder, trial subtract, shift quotient bit in
  always_comb begin
    rem2     = {rem_r, 1'b0};
    diff     = rem2 - {1'b0, den_r};
    fits     = rem2 >= {1'b0, den_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      den_nxt  = denom;
      rem_nxt  = {1'b0, limit};
      q_nxt    = '0;
    end else if (busy_r) begin
      rem_nxt = fits ? diff[DW-1:0] : rem2[DW-1:0];
      q_nxt   = {q_r[QW-2:0], fits};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == LAST_STEP) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    den_r <= den_nxt;
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
  end

  assign quot     = q_r;
  assign sts.busy = busy_r;
  assign sts.done = done_r;

endmodule

`default_nettype wire

@@ dv/tb.sv @@
// testbench for adaptive_gain_audio_mixer: directed and random PCM pairs, gain tracked in Q1.16
// depends on agm_pkg and the adaptive_gain_audio_mixer rtl
`timescale 1ns / 1ps

module tb;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 238;
  localparam int DRAIN_CYCLES = 80;
  localparam int MAX_PRINTS   = 40;

  // tracks the running gain and holds the mixed samples still owed by the block
  class gain_mix_scoreboard;
    logic [agm_pkg::GAIN_W-1:0]  gain_q16;
    logic [agm_pkg::SHIFT_W-1:0] recovery_shift;
    agm_pkg::agm_out_t           expected_mix[$];
    int                          results_seen;
    int                          errors;

    function new();
      gain_q16       = agm_pkg::GAIN_ONE;
      recovery_shift = agm_pkg::RECOVERY_SHIFT_RST;
      results_seen   = 0;
      errors         = 0;
    endfunction

    function void report(string msg);
      if (errors < MAX_PRINTS) begin
        $display("error at %0t: %s", $realtime, msg);
      end
      errors++;
    endfunction

    // mix one accepted pair and queue the expected result
    function void note_sample(agm_pkg::agm_in_t x);
      int                sum;
      int                sa;
      int                sb_v;
      longint unsigned   mag;
      longint unsigned   smag;
      agm_pkg::agm_out_t r;
      sa   = x.sample_a;
      sb_v = x.sample_b;
      sum  = sa + sb_v;
      mag  = (sum < 0) ? longint'(-sum) : longint'(sum);
      smag = (mag * 64'(gain_q16)) >> 16;
      r.clipped = 1'b0;
      if (sum >= 0 && smag > 64'(agm_pkg::LIMIT_POS)) begin
        // positive clip, gain becomes limit over scaled value
        gain_q16       = agm_pkg::GAIN_W'((64'(agm_pkg::LIMIT_POS) << 16) / smag);
        r.mixed_sample = agm_pkg::LIMIT_POS;
        r.clipped      = 1'b1;
      end else if (sum < 0 && smag > 64'(agm_pkg::LIMIT_NEG_MAG)) begin
        // negative clip
        gain_q16       = agm_pkg::GAIN_W'((64'(agm_pkg::LIMIT_NEG_MAG) << 16) / smag);
        r.mixed_sample = agm_pkg::LIMIT_NEG_MAG;
        r.clipped      = 1'b1;
      end else if (sum < 0) begin
        r.mixed_sample = -smag[agm_pkg::SAMPLE_W-1:0];
      end else begin
        r.mixed_sample = smag[agm_pkg::SAMPLE_W-1:0];
      end
      // recovery toward unity, then block boundary reset
      if (gain_q16 < agm_pkg::GAIN_ONE) begin
        gain_q16 = gain_q16 + ((agm_pkg::GAIN_ONE - gain_q16) >> recovery_shift);
      end
      if (x.last_in_block) begin
        gain_q16 = agm_pkg::GAIN_ONE;
      end
      expected_mix = {expected_mix, r};
    endfunction

    // compare one result transaction with the oldest expectation
    function void check_result(agm_pkg::agm_out_t y);
      agm_pkg::agm_out_t e;
      results_seen++;
      if (expected_mix.size() == 0) begin
        report($sformatf("unexpected result mixed_sample=%0d clipped=%0b",
                         y.mixed_sample, y.clipped));
        return;
      end
      e = expected_mix.pop_front();
      if (y.mixed_sample !== e.mixed_sample) begin
        report($sformatf("mixed_sample got %0d want %0d", y.mixed_sample, e.mixed_sample));
      end
      if (y.clipped !== e.clipped) begin
        report($sformatf("clipped got %0b want %0b", y.clipped, e.clipped));
      end
    endfunction
  endclass

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  agm_pkg::agm_in_t            in_data = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  agm_pkg::agm_out_t           out_data;
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic [agm_pkg::SHIFT_W-1:0] cfg_data = '0;

  int in_idle_pct  = 0;
  int out_stall_pct = 0;
  int items_sent   = 0;
  int cycles       = 0;

  gain_mix_scoreboard sb = new();

  adaptive_gain_audio_mixer u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("adaptive_gain_audio_mixer: mismatch");
      $finish;
    end
  end

  // random backpressure on the result channel
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < out_stall_pct);
  end

  // watch both channels
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        sb.note_sample(in_data);
      end
      if (out_valid && !out_stall) begin
        sb.check_result(out_data);
      end
    end
  end

  // drive one input transaction, idling a random number of cycles first
  task automatic send_sample(agm_pkg::agm_in_t x);
    while (in_idle_pct > 0 && $urandom_range(0, 99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= x;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  // wait until every accepted transaction has produced its result
  task automatic wait_drained();
    while (sb.results_seen < items_sent) @(posedge clk);
  endtask

  task automatic write_shift(logic [agm_pkg::SHIFT_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.recovery_shift = v;
    cfg_valid <= 1'b0;
  endtask

  // limits, exact -32768, clips both ways, block ends, alternating bit patterns
  agm_pkg::agm_in_t directed_list [16] = '{
    '{16'h0000, 16'h0000, 1'b0},
    '{16'h7fff, 16'h0000, 1'b0},
    '{16'h8000, 16'h0000, 1'b0},
    '{16'hc000, 16'hc000, 1'b0},
    '{16'h8000, 16'hffff, 1'b0},
    '{16'h0064, 16'h00c8, 1'b0},
    '{16'h7fff, 16'h7fff, 1'b0},
    '{16'h8000, 16'h8000, 1'b1},
    '{16'h7fff, 16'h7fff, 1'b0},
    '{16'h0001, 16'hffff, 1'b1},
    '{16'h8000, 16'h7fff, 1'b0},
    '{16'h4000, 16'h4000, 1'b0},
    '{16'hffff, 16'hffff, 1'b0},
    '{16'h5555, 16'h2aaa, 1'b0},
    '{16'haaaa, 16'h5555, 1'b1},
    '{16'h7fff, 16'h8000, 1'b1}
  };

  initial begin
    logic [agm_pkg::SHIFT_W-1:0] shift_plan [PHASES];
    agm_pkg::agm_in_t            x;
    int                          kind;

    shift_plan = '{4'd0, 4'd15, 4'd1, 4'd5, 4'd15, 4'd0, 4'd3, 4'd9};
    shift_plan[6] = agm_pkg::SHIFT_W'($urandom_range(0, 15));
    shift_plan[7] = agm_pkg::SHIFT_W'($urandom_range(0, 15));

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part at the reset shift
    foreach (directed_list[i]) begin
      send_sample(directed_list[i]);
    end
    in_valid <= 1'b0;
    wait_drained();

    // random phases: each sets a new shift and an idling mode
    for (int p = 0; p < PHASES; p++) begin
      write_shift(shift_plan[p]);
      case (p % 4)
        0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
        1: begin in_idle_pct = 68; out_stall_pct = 0;  end
        2: begin in_idle_pct = 0;  out_stall_pct = 68; end
        default: begin in_idle_pct = 29; out_stall_pct = 29; end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        kind = $urandom_range(0, 19);
        if (kind < 8) begin
          // full scale, clips often
          x.sample_a = agm_pkg::SAMPLE_W'($urandom);
          x.sample_b = agm_pkg::SAMPLE_W'($urandom);
        end else if (kind < 14) begin
          // half scale, never clips so the gain can recover
          x.sample_a = agm_pkg::SAMPLE_W'($urandom_range(0, 32767) - 16384);
          x.sample_b = agm_pkg::SAMPLE_W'($urandom_range(0, 32767) - 16384);
        end else if (kind < 17) begin
          // near the limits
          x.sample_a = $urandom_range(0, 1)
                     ? agm_pkg::SAMPLE_W'(32767 - $urandom_range(0, 3))
                     : agm_pkg::SAMPLE_W'(-32768 + $urandom_range(0, 3));
          x.sample_b = agm_pkg::SAMPLE_W'($urandom_range(0, 2) - 1);
          if ($urandom_range(0, 1)) begin
            x.sample_b = x.sample_a;
          end
        end else begin
          // small values
          x.sample_a = agm_pkg::SAMPLE_W'($urandom_range(0, 512) - 256);
          x.sample_b = agm_pkg::SAMPLE_W'($urandom_range(0, 512) - 256);
        end
        x.last_in_block = ($urandom_range(0, 15) == 0);
        send_sample(x);
      end
      in_valid <= 1'b0;
      wait_drained();
    end

    out_stall_pct = 0;
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.expected_mix.size() != 0) begin
      sb.report($sformatf("%0d results never arrived", sb.expected_mix.size()));
    end
    if (sb.errors == 0) begin
      $display("adaptive_gain_audio_mixer: match");
    end else begin
      $display("adaptive_gain_audio_mixer: mismatch");
    end
    $finish;
  end

endmodule

@@ adaptive_gain_audio_mixer.f @@
design/agm_pkg.sv
design/agm_mul.sv
design/agm_div.sv
design/adaptive_gain_audio_mixer.sv
dv/tb.sv
